@@ src/fgc_pkg.sv @@
`timescale 1ns / 1ps
package fgc_pkg;
   typedef logic [63:0] word_type;

   localparam int Q_W      = 64;
   localparam int MUL_LAT  = 2;
   localparam int DIV_LAT  = Q_W + 1;
   localparam int DIV5_LAT = 2;
   localparam int SQ_IN_W  = 56;
   localparam int SQ_OUT_W = SQ_IN_W / 2;
   localparam int SQ_LAT   = SQ_OUT_W + 1;

   localparam int REQ_W  = 152;
   localparam int RSP_W  = 32;
   localparam int USER_W = 1;
   localparam int CSR_IW = 1;
   localparam int CSR_DW = 32;

   localparam logic [CSR_IW-1:0] REG_RESTITUTION   = 1'b0;
   localparam logic [CSR_IW-1:0] REG_FILTER_LENGTH = 1'b1;

   localparam logic [15:0] RST_RESTITUTION   = 16'd58982;
   localparam logic [31:0] RST_FILTER_LENGTH = 32'd167772;

   localparam word_type ONE_Q    = 64'h0000_0001_0000_0000;
   localparam word_type THREE_Q  = 64'h0000_0003_0000_0000;
   localparam word_type FIVE_Q   = 64'h0000_0005_0000_0000;
   localparam word_type SIX_Q    = 64'h0000_0006_0000_0000;
   localparam word_type TWELVE_Q = 64'h0000_000C_0000_0000;
   localparam word_type C41_Q    = 64'h0000_0029_0000_0000;
   localparam word_type SATV     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam word_type K_DIL    = 64'd11894736442;
   localparam word_type K_S62    = 64'd36444005999;
   localparam word_type K_256PI  = 64'd3499854211;
   localparam word_type K_EPS    = 64'd429;
   localparam word_type RECIP5   = 64'hCCCC_CCCC_CCCC_CCCD;

   function automatic word_type sadd(input word_type a, input word_type b);
      logic [Q_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[Q_W] ? SATV : s[Q_W-1:0];
   endfunction
endpackage

@@ src/fgc_mul.sv @@
`timescale 1ns / 1ps
module fgc_mul (
   input  logic              clock,
   input  logic              adv,
   input  fgc_pkg::word_type a,
   input  fgc_pkg::word_type b,
   output fgc_pkg::word_type p
);
   import fgc_pkg::*;
   localparam int H = Q_W / 2;

   logic [Q_W-1:0]   p0_ff, p1_ff, p2_ff, p3_ff;
   logic [2*Q_W-1:0] full;
   word_type         p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= a[H-1:0] * b[H-1:0];
         p1_ff <= a[H-1:0] * b[Q_W-1:H];
         p2_ff <= a[Q_W-1:H] * b[H-1:0];
         p3_ff <= a[Q_W-1:H] * b[Q_W-1:H];
      end
   end

   assign full = {p3_ff, {Q_W{1'b0}}} + {{H{1'b0}}, p1_ff, {H{1'b0}}}
               + {{H{1'b0}}, p2_ff, {H{1'b0}}} + {{Q_W{1'b0}}, p0_ff};

   // clip when the product overflows Q32.32
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= (full[2*Q_W-1:Q_W+H] != '0) ? SATV : full[Q_W+H-1:H];
      end
   end

   assign p = p_ff;
endmodule

@@ src/fgc_div.sv @@
`timescale 1ns / 1ps
module fgc_div (
   input  logic              clock,
   input  logic              adv,
   input  fgc_pkg::word_type num,
   input  fgc_pkg::word_type den,
   output fgc_pkg::word_type quo
);
   import fgc_pkg::*;
   localparam int H = Q_W / 2;

   word_type       rem_ff [0:Q_W];
   logic [H-1:0]   lo_ff  [0:Q_W];
   word_type       den_ff [0:Q_W];
   word_type       q_ff   [0:Q_W];
   logic           sat_ff [0:Q_W];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= {{H{1'b0}}, num[Q_W-1:H]};
         lo_ff[0]  <= num[H-1:0];
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= ({{H{1'b0}}, num[Q_W-1:H]} >= den);
      end
   end

   for (genvar i = 1; i <= Q_W; i++) begin : g_step
      logic [Q_W:0] shifted;
      logic         take;
      assign shifted = {rem_ff[i-1], lo_ff[i-1][H-1]};
      assign take    = shifted >= {1'b0, den_ff[i-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= take ? Q_W'(shifted - {1'b0, den_ff[i-1]})
                              : shifted[Q_W-1:0];
            lo_ff[i]  <= {lo_ff[i-1][H-2:0], 1'b0};
            den_ff[i] <= den_ff[i-1];
            q_ff[i]   <= {q_ff[i-1][Q_W-2:0], take};
            sat_ff[i] <= sat_ff[i-1];
         end
      end
   end

   assign quo = sat_ff[Q_W] ? SATV : q_ff[Q_W];
endmodule

// Q32.32 divide by the constant 5: the high part of num times ceil(2^66 / 5)
module fgc_div5 (
   input  logic              clock,
   input  logic              adv,
   input  fgc_pkg::word_type num,
   output fgc_pkg::word_type quo
);
   import fgc_pkg::*;
   localparam int H = Q_W / 2;

   logic [Q_W-1:0]   p0_ff, p1_ff, p2_ff, p3_ff;
   logic [2*Q_W-1:0] full;
   word_type         q_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= num[H-1:0] * RECIP5[H-1:0];
         p1_ff <= num[H-1:0] * RECIP5[Q_W-1:H];
         p2_ff <= num[Q_W-1:H] * RECIP5[H-1:0];
         p3_ff <= num[Q_W-1:H] * RECIP5[Q_W-1:H];
      end
   end

   assign full = {p3_ff, {Q_W{1'b0}}} + {{H{1'b0}}, p1_ff, {H{1'b0}}}
               + {{H{1'b0}}, p2_ff, {H{1'b0}}} + {{Q_W{1'b0}}, p0_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff <= {2'b00, full[2*Q_W-1:Q_W+2]};
      end
   end

   assign quo = q_ff;
endmodule

@@ src/fgc_sqrt.sv @@
`timescale 1ns / 1ps
module fgc_sqrt (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [fgc_pkg::SQ_IN_W-1:0]  rad,
   output logic [fgc_pkg::SQ_OUT_W-1:0] root
);
   import fgc_pkg::*;
   localparam int RW = SQ_OUT_W + 1;

   logic [SQ_IN_W-1:0]  rad_ff  [0:SQ_OUT_W];
   logic [RW-1:0]       rem_ff  [0:SQ_OUT_W];
   logic [SQ_OUT_W-1:0] root_ff [0:SQ_OUT_W];

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0]  <= rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar i = 1; i <= SQ_OUT_W; i++) begin : g_digit
      logic [RW+1:0] shifted, trial;
      logic          take;
      assign shifted = {rem_ff[i-1], rad_ff[i-1][SQ_IN_W-1 -: 2]};
      assign trial   = {{(RW-SQ_OUT_W){1'b0}}, root_ff[i-1], 2'b01};
      assign take    = shifted >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[i]  <= {rad_ff[i-1][SQ_IN_W-3:0], 2'b00};
            rem_ff[i]  <= take ? RW'(shifted - trial) : shifted[RW-1:0];
            root_ff[i] <= {root_ff[i-1][SQ_OUT_W-2:0], take};
         end
      end
   end

   assign root = root_ff[SQ_OUT_W];
endmodule

@@ src/fgc_dly.sv @@
`timescale 1ns / 1ps
module fgc_dly #(
   parameter int W = 64,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         adv,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] tap_ff [0:N-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         tap_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[N-1];
endmodule

@@ src/filtered_granular_conductivity.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Ports                         Contents
// request   in   req_tvalid/tready/tdata       one cell's six input fields
// response  out  rsp_tvalid/tready/tdata/tuser conductivity, saturation flag
// csr       in   csr_valid/ready/index/data    restitution, filter length
//
// One cell enters per cycle while the response is not stalled.
// The latency is set by the longest path: the square root, then six 64-bit
// dividers in series (65 stages each, one quotient bit per stage after the first),
// with the multipliers and divides by 5 between them.
// Reset (synchronous) empties the pipeline and restores the csr defaults.
// A stalled response freezes the whole pipeline; nothing is dropped.
module filtered_granular_conductivity (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // solid_fraction, granular_temp, radial_dist, density, diameter, drag_coeff
   input  logic [fgc_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // conductivity
   output logic [fgc_pkg::RSP_W-1:0]   rsp_tdata,
   // saturated
   output logic [fgc_pkg::USER_W-1:0]  rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fgc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [fgc_pkg::CSR_DW-1:0]  csr_data
);
   import fgc_pkg::*;

   localparam int T_ST   = SQ_LAT;
   localparam int T_M3   = T_ST + MUL_LAT;
   localparam int T_K0   = T_M3 + DIV_LAT;
   localparam int T_R3   = T_K0 + 2 * MUL_LAT + DIV5_LAT;
   localparam int T_R6   = T_R3 + 3 * DIV_LAT;
   localparam int T_S1   = T_R6 + 1;
   localparam int T_KS   = T_S1 + DIV_LAT;
   localparam int T_BASE = T_KS + DIV_LAT;
   localparam int T_IL   = MUL_LAT + 3 * DIV_LAT + 1;
   localparam int T_EAG  = 2 * MUL_LAT;
   localparam int T_T1B  = T_EAG + MUL_LAT + DIV5_LAT;
   localparam int T_T1   = T_IL + 1;
   localparam int T_F2   = 4 * MUL_LAT + DIV5_LAT + 1;
   localparam int T_T3   = T_EAG + 2 * MUL_LAT;
   localparam int T_P    = T_T1 + MUL_LAT;
   localparam int T_CORE = T_P + 1;
   localparam int T_RES  = T_BASE + MUL_LAT;

   logic        adv;
   logic [15:0] restitution_ff;
   logic [31:0] filter_length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff   <= RST_RESTITUTION;
         filter_length_ff <= RST_FILTER_LENGTH;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RESTITUTION:   restitution_ff   <= csr_data[15:0];
            REG_FILTER_LENGTH: filter_length_ff <= csr_data;
            default:           restitution_ff   <= restitution_ff;
         endcase
      end
   end

   word_type eta, c, e4, dd, len;
   logic     neg;

   always_comb begin
      eta = {32'd0, ({1'b0, restitution_ff} + 17'h10000), 15'd0};
      c   = C41_Q - (eta * 64'd33);
      e4  = eta << 2;
      neg = e4 < THREE_Q;
      dd  = neg ? (THREE_Q - e4) : (e4 - THREE_Q);
      len = {24'd0, ((filter_length_ff != '0) ? filter_length_ff : 32'd1), 8'd0};
   end

   // input stage
   logic        v0_ff;
   logic [15:0] a_ff, r_ff;
   logic [31:0] t_ff, d_ff, k_ff;
   logic [23:0] g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= req_tdata[15:0];
         t_ff <= req_tdata[47:16];
         g_ff <= req_tdata[71:48];
         r_ff <= req_tdata[87:72];
         d_ff <= req_tdata[119:88];
         k_ff <= req_tdata[151:120];
      end
   end

   word_type alpha, th, g, rho, diam, kd, apad;
   logic     zero;

   assign alpha = {32'd0, a_ff, 16'd0};
   assign th    = {24'd0, t_ff, 8'd0};
   assign g     = {24'd0, g_ff, 16'd0};
   assign rho   = {16'd0, r_ff, 32'd0};
   assign diam  = {32'd0, d_ff};
   assign kd    = {8'd0, k_ff, 24'd0};
   assign apad  = alpha + K_EPS;
   assign zero  = (a_ff == '0) || (t_ff == '0) || (g_ff == '0);

   // dilute conductivity k0
   logic [SQ_OUT_W-1:0] root;
   word_type st, m1, m2, m2_d, m3, den, den_d, k0, diam_d;

   fgc_sqrt u_sqrt (.clock, .adv, .rad({t_ff, 24'd0}), .root);
   assign st = {28'd0, root, 8'd0};

   fgc_dly #(.W(Q_W), .N(MUL_LAT)) u_dl_d (.clock, .adv, .d(diam), .q(diam_d));
   fgc_mul u_m1 (.clock, .adv, .a(K_DIL), .b(rho), .p(m1));
   fgc_mul u_m2 (.clock, .adv, .a(m1), .b(diam_d), .p(m2));
   fgc_dly #(.W(Q_W), .N(T_ST - 2 * MUL_LAT)) u_dl_m2 (.clock, .adv, .d(m2), .q(m2_d));
   fgc_mul u_m3 (.clock, .adv, .a(m2_d), .b(st), .p(m3));
   fgc_mul u_den (.clock, .adv, .a(eta), .b(c), .p(den));
   fgc_dly #(.W(Q_W), .N(T_M3 - MUL_LAT)) u_dl_den (.clock, .adv, .d(den), .q(den_d));
   fgc_div u_k0 (.clock, .adv, .num(m3), .den(den_d), .quo(k0));

   // drag correction and kstar
   word_type kd_d, r1, r2, r3, ar, ar2, ar2_d, r4, g_d1, r5, th_d, r6, s1_ff, k0_d, ks;
   word_type g_d2, base;

   fgc_dly #(.W(Q_W), .N(T_K0)) u_dl_kd (.clock, .adv, .d(kd), .q(kd_d));
   fgc_mul u_r1 (.clock, .adv, .a(kd_d), .b(k0), .p(r1));
   fgc_mul u_r2 (.clock, .adv, .a(r1), .b(SIX_Q), .p(r2));
   fgc_div5 u_r3 (.clock, .adv, .num(r2), .quo(r3));
   fgc_mul u_ar (.clock, .adv, .a(alpha), .b(rho), .p(ar));
   fgc_mul u_ar2 (.clock, .adv, .a(ar), .b(ar), .p(ar2));
   fgc_dly #(.W(Q_W), .N(T_R3 - 2 * MUL_LAT)) u_dl_ar2 (.clock, .adv, .d(ar2), .q(ar2_d));
   fgc_div u_r4 (.clock, .adv, .num(r3), .den(ar2_d), .quo(r4));
   fgc_dly #(.W(Q_W), .N(T_R3 + DIV_LAT)) u_dl_g1 (.clock, .adv, .d(g), .q(g_d1));
   fgc_div u_r5 (.clock, .adv, .num(r4), .den(g_d1), .quo(r5));
   fgc_dly #(.W(Q_W), .N(T_R3 + 2 * DIV_LAT)) u_dl_th (.clock, .adv, .d(th), .q(th_d));
   fgc_div u_r6 (.clock, .adv, .num(r5), .den(th_d), .quo(r6));

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= sadd(ONE_Q, r6);
      end
   end

   fgc_dly #(.W(Q_W), .N(T_S1 - T_K0)) u_dl_k0 (.clock, .adv, .d(k0), .q(k0_d));
   fgc_div u_ks (.clock, .adv, .num(k0_d), .den(s1_ff), .quo(ks));
   fgc_dly #(.W(Q_W), .N(T_KS)) u_dl_g2 (.clock, .adv, .d(g), .q(g_d2));
   fgc_div u_base (.clock, .adv, .num(ks), .den(g_d2), .quo(base));

   // filter correction 1/lambda
   word_type mlx, lx1, lx, l1_ff, inv_lam;

   fgc_mul u_mlx (.clock, .adv, .a(K_S62), .b(apad), .p(mlx));
   fgc_div u_lx1 (.clock, .adv, .num(diam_d), .den(mlx), .quo(lx1));
   fgc_div u_lx (.clock, .adv, .num(lx1), .den(len), .quo(lx));

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff <= sadd(ONE_Q, lx);
      end
   end

   fgc_div u_il (.clock, .adv, .num(ONE_Q), .den(l1_ff), .quo(inv_lam));

   // first factor of the bracket
   word_type ag, eag, t1a, t1b, t1b_d, t1_ff;

   fgc_mul u_ag (.clock, .adv, .a(alpha), .b(g), .p(ag));
   fgc_mul u_eag (.clock, .adv, .a(eta), .b(ag), .p(eag));
   fgc_mul u_t1a (.clock, .adv, .a(eag), .b(TWELVE_Q), .p(t1a));
   fgc_div5 u_t1b (.clock, .adv, .num(t1a), .quo(t1b));
   fgc_dly #(.W(Q_W), .N(T_IL - T_T1B)) u_dl_t1b (.clock, .adv, .d(t1b), .q(t1b_d));

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= sadd(inv_lam, t1b_d);
      end
   end

   // second factor of the bracket, may go negative
   word_type ee, ue1, ag_d, ue2, ue3, u, f2_ff, f2_d;
   logic     f2neg_ff, f2neg_d;

   fgc_mul u_ee (.clock, .adv, .a(eta), .b(eta), .p(ee));
   fgc_mul u_ue1 (.clock, .adv, .a(ee), .b(dd), .p(ue1));
   fgc_dly #(.W(Q_W), .N(MUL_LAT)) u_dl_ag (.clock, .adv, .d(ag), .q(ag_d));
   fgc_mul u_ue2 (.clock, .adv, .a(ue1), .b(ag_d), .p(ue2));
   fgc_mul u_ue3 (.clock, .adv, .a(ue2), .b(TWELVE_Q), .p(ue3));
   fgc_div5 u_u (.clock, .adv, .num(ue3), .quo(u));

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!neg) begin
            f2_ff    <= sadd(ONE_Q, u);
            f2neg_ff <= 1'b0;
         end else if (u <= ONE_Q) begin
            f2_ff    <= ONE_Q - u;
            f2neg_ff <= 1'b0;
         end else begin
            f2_ff    <= u - ONE_Q;
            f2neg_ff <= 1'b1;
         end
      end
   end

   fgc_dly #(.W(Q_W), .N(T_T1 - T_F2)) u_dl_f2 (.clock, .adv, .d(f2_ff), .q(f2_d));
   fgc_dly #(.W(1), .N(T_P - T_F2)) u_dl_f2n (.clock, .adv, .d(f2neg_ff), .q(f2neg_d));

   // dense term
   word_type kc, kc_d, e2, t3, t3_d;

   fgc_mul u_kc (.clock, .adv, .a(K_256PI), .b(c), .p(kc));
   fgc_dly #(.W(Q_W), .N(T_EAG)) u_dl_kc (.clock, .adv, .d(kc), .q(kc_d));
   fgc_mul u_e2 (.clock, .adv, .a(eag), .b(eag), .p(e2));
   fgc_mul u_t3 (.clock, .adv, .a(kc_d), .b(e2), .p(t3));
   fgc_dly #(.W(Q_W), .N(T_P - T_T3)) u_dl_t3 (.clock, .adv, .d(t3), .q(t3_d));

   // combine the bracket, clamp at zero when negative
   word_type p, core_ff, core_d, res;

   fgc_mul u_p (.clock, .adv, .a(t1_ff), .b(f2_d), .p(p));

   always_ff @(posedge clock) begin
      if (adv) begin
         if (f2neg_d) begin
            core_ff <= (t3_d > p) ? (t3_d - p) : '0;
         end else begin
            core_ff <= sadd(p, t3_d);
         end
      end
   end

   fgc_dly #(.W(Q_W), .N(T_BASE - T_CORE)) u_dl_core (.clock, .adv, .d(core_ff),
                                                       .q(core_d));
   fgc_mul u_res (.clock, .adv, .a(base), .b(core_d), .p(res));

   // valid bits and zero-input flag travel alongside
   logic [T_RES-1:0] v_ff;
   logic             zero_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[T_RES-2:0], v0_ff};
      end
   end

   fgc_dly #(.W(1), .N(T_RES)) u_dl_zero (.clock, .adv, .d(zero), .q(zero_d));

   // output register
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] cond_ff;
   logic             sat_ff;
   logic             clip;

   assign clip = res[Q_W-1:48] != '0;
   assign adv  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[T_RES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cond_ff <= zero_d ? '0 : (clip ? '1 : res[47:16]);
         sat_ff  <= !zero_d && clip;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = cond_ff;
   assign rsp_tuser  = sat_ff;
endmodule

@@ src/fgc_checker.sv @@
`timescale 1ns / 1ps
module fgc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [fgc_pkg::RSP_W-1:0]  rsp_tdata,
   input logic [fgc_pkg::USER_W-1:0] rsp_tuser
);
   import fgc_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '1)
      else $error("saturated response not at maximum");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready not tied to response drain");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");
endmodule

bind filtered_granular_conductivity fgc_checker u_fgc_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
